>>> src/depth_pixel_backproject_mask_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depth pixel back-projection block
// Concurrent checks on the clk_i / rst_ni domain; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_BACKPROJECT_MASK_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECT_MASK_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on an explicit clock and active-low reset
`define DPBM_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dpbm assertion failed");

// Check a property on the block clock and reset
`define DPBM_ASSERT(lbl, prop) \
  `DPBM_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`else

`define DPBM_ASSERT_CLK(lbl, clk, rstn, prop)
`define DPBM_ASSERT(lbl, prop)

`endif

`endif

>>> src/dpbm_pkg.sv
// ----------------------------------------------------------------------------
// dpbm_pkg
// Types and fixed-point constants of the depth pixel back-projection block.
// ----------------------------------------------------------------------------
package dpbm_pkg;

  // Configuration register indexes
  typedef enum logic [3:0] {
    CFG_INV_FOCAL_X    = 4'd0,
    CFG_INV_FOCAL_Y    = 4'd1,
    CFG_CENTER_X_Q4    = 4'd2,
    CFG_CENTER_Y_Q4    = 4'd3,
    CFG_WORLD_Z_FROM_X = 4'd4,
    CFG_WORLD_Z_FROM_Y = 4'd5,
    CFG_WORLD_Z_FROM_Z = 4'd6,
    CFG_Z_PLANE_OFFSET = 4'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 24;

  // Field widths
  localparam int unsigned CoordW   = 12;
  localparam int unsigned CenterW  = 16;
  localparam int unsigned InvW     = 24;
  localparam int unsigned DepthW   = 16;
  localparam int unsigned ZW       = 10;
  localparam int unsigned ColorW   = 8;
  localparam int unsigned RotW     = 18;
  localparam int unsigned OffsetW  = 21;
  localparam int unsigned Q4W      = 19;

  // Datapath widths
  localparam int unsigned DxW      = 18;  // 16*coord - center
  localparam int unsigned Prod1W   = DxW + ZW + 1;
  localparam int unsigned Prod2W   = Prod1W + InvW + 1;
  localparam int unsigned RoundW   = 27;  // |x| < 2^26 mm Q4
  localparam int unsigned FracBits = 24;
  localparam int unsigned MxyW     = RotW + RoundW;
  localparam int unsigned MzW      = RotW + ZW + 4 + 1;
  localparam int unsigned WW       = 47;

  localparam logic [DepthW-1:0] DEPTH_LIMIT_MM = 16'd1000;
  localparam logic [ColorW-1:0] ALPHA_OPAQUE   = 8'd255;

  localparam logic signed [Q4W-1:0] Q4_MAX = 19'sh1FFFF + 19'sh20000;
  localparam logic signed [Q4W-1:0] Q4_MIN = -Q4_MAX - 19'sd1;

  // Load strobes for the stages of one projection lane
  typedef struct packed {
    logic dx;
    logic scale;
    logic focal;
    logic rnd;
  } axis_en_t;

  // Side data that rides along the pipeline
  typedef struct packed {
    logic              ok;
    logic [ZW-1:0]     z;
    logic [ColorW-1:0] b;
    logic [ColorW-1:0] g;
    logic [ColorW-1:0] r;
  } side_t;

endpackage

>>> src/dpbm_axis.sv
// ----------------------------------------------------------------------------
// dpbm_axis
// One projection lane: (16*coord - center) * depth * inv_focal, rounded to
// mm Q4 with halves away from zero. Four register stages.
// ----------------------------------------------------------------------------
module dpbm_axis (
  input  logic                              clk_i,
  input  dpbm_pkg::axis_en_t                en_i,
  input  logic [dpbm_pkg::CoordW-1:0]       coord_i,
  input  logic [dpbm_pkg::CenterW-1:0]      center_i,
  input  logic [dpbm_pkg::ZW-1:0]           depth_i,
  input  logic [dpbm_pkg::InvW-1:0]         inv_focal_i,
  output logic signed [dpbm_pkg::RoundW-1:0] coord_q4_o
);
  import dpbm_pkg::*;

  localparam logic signed [Prod2W-1:0] RndPos = Prod2W'(64'd1 << (FracBits - 1));
  localparam logic signed [Prod2W-1:0] RndNeg = RndPos - Prod2W'(1);

  logic signed [DxW-1:0]    dx_d, dx_q;
  logic signed [Prod1W-1:0] prod1_d, prod1_q;
  logic signed [Prod2W-1:0] prod2_d, prod2_q;
  logic signed [Prod2W-1:0] rsum;
  logic signed [RoundW-1:0] rnd_d, rnd_q;

  // Offset from the principal point in Q4 pixels
  assign dx_d = $signed({2'b00, coord_i, 4'b0000}) - $signed({2'b00, center_i});

  // Scale by depth, then by the focal reciprocal
  assign prod1_d = dx_q * $signed({1'b0, depth_i});
  assign prod2_d = prod1_q * $signed({1'b0, inv_focal_i});

  // Round halves away from zero: bias one less for negative products
  assign rsum  = prod2_q + (prod2_q[Prod2W-1] ? RndNeg : RndPos);
  assign rnd_d = rsum[FracBits +: RoundW];

  // Advance each stage on its own strobe
  always_ff @(posedge clk_i) begin
    if (en_i.dx) begin
      dx_q <= dx_d;
    end
    if (en_i.scale) begin
      prod1_q <= prod1_d;
    end
    if (en_i.focal) begin
      prod2_q <= prod2_d;
    end
    if (en_i.rnd) begin
      rnd_q <= rnd_d;
    end
  end

  assign coord_q4_o = rnd_q;

endmodule

>>> src/depth_pixel_backproject_mask.sv
// ----------------------------------------------------------------------------
// depth_pixel_backproject_mask
// Pinhole back-projection of one depth pixel to a camera point in mm Q4,
// with depth masking, BGRA colour and a workspace floor test.
//
//   channel  signals                          direction  beat
//   in       in_valid_i / in_ready_o          sink       one pixel
//   out      out_valid_o / out_ready_i        source     one point
//   cfg      cfg_valid_i / cfg_ready_o        sink       one register write
//
// Seven register stages: offset, depth scale, focal scale, round,
// saturate and rotate, world z sum, floor compare into the output register.
// One pixel per cycle while the output is not stalled.
// Each stage has its own valid bit and loads when it is empty or its
// successor loads, so bubbles collapse and a stall drops nothing.
// Reset clears the valid bits and loads the register defaults; cfg_ready_o
// is always high.
// ----------------------------------------------------------------------------
`include "depth_pixel_backproject_mask_defines.svh"

module depth_pixel_backproject_mask #(
  parameter int unsigned MAX_COLUMNS = 4096,
  parameter int unsigned MAX_ROWS    = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pixel input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dpbm_pkg::CoordW-1:0]       column_i,
  input  logic [dpbm_pkg::CoordW-1:0]       row_index_i,
  input  logic [dpbm_pkg::DepthW-1:0]       depth_mm_i,
  input  logic [dpbm_pkg::ColorW-1:0]       blue_in_i,
  input  logic [dpbm_pkg::ColorW-1:0]       green_in_i,
  input  logic [dpbm_pkg::ColorW-1:0]       red_in_i,
  // point output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              point_valid_o,
  output logic signed [dpbm_pkg::Q4W-1:0]   x_q4_o,
  output logic signed [dpbm_pkg::Q4W-1:0]   y_q4_o,
  output logic [dpbm_pkg::ZW-1:0]           z_mm_o,
  output logic [dpbm_pkg::ColorW-1:0]       blue_out_o,
  output logic [dpbm_pkg::ColorW-1:0]       green_out_o,
  output logic [dpbm_pkg::ColorW-1:0]       red_out_o,
  output logic [dpbm_pkg::ColorW-1:0]       alpha_out_o,
  output logic                              in_workspace_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dpbm_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [dpbm_pkg::CfgDataW-1:0]     cfg_data_i
);
  import dpbm_pkg::*;

  localparam int unsigned NumStages = 7;
  localparam int unsigned LimW      = 17;
  localparam logic [LimW-1:0] MaxCol = LimW'(MAX_COLUMNS);
  localparam logic [LimW-1:0] MaxRow = LimW'(MAX_ROWS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [InvW-1:0]           inv_focal_x_q, inv_focal_y_q;
  logic [CenterW-1:0]        center_x_q, center_y_q;
  logic signed [RotW-1:0]    wz_x_q, wz_y_q, wz_z_q;
  logic signed [OffsetW-1:0] z_off_q;

  assign cfg_ready_o = 1'b1;

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_focal_x_q <= 24'd33554;
      inv_focal_y_q <= 24'd33554;
      center_x_q    <= 16'd5120;
      center_y_q    <= 16'd3840;
      wz_x_q        <= '0;
      wz_y_q        <= '0;
      wz_z_q        <= 18'sd65536;
      z_off_q       <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INV_FOCAL_X:    inv_focal_x_q <= cfg_data_i[InvW-1:0];
        CFG_INV_FOCAL_Y:    inv_focal_y_q <= cfg_data_i[InvW-1:0];
        CFG_CENTER_X_Q4:    center_x_q    <= cfg_data_i[CenterW-1:0];
        CFG_CENTER_Y_Q4:    center_y_q    <= cfg_data_i[CenterW-1:0];
        CFG_WORLD_Z_FROM_X: wz_x_q        <= $signed(cfg_data_i[RotW-1:0]);
        CFG_WORLD_Z_FROM_Y: wz_y_q        <= $signed(cfg_data_i[RotW-1:0]);
        CFG_WORLD_Z_FROM_Z: wz_z_q        <= $signed(cfg_data_i[RotW-1:0]);
        CFG_Z_PLANE_OFFSET: z_off_q       <= $signed(cfg_data_i[OffsetW-1:0]);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage flow control
  // --------------------------------------------------------------------------
  logic [NumStages:1] valid_q;
  logic [NumStages:1] ld;

  // A stage loads when it is empty or its successor loads
  always_comb begin
    ld[NumStages] = !valid_q[NumStages] || out_ready_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      ld[k] = !valid_q[k] || ld[k+1];
    end
  end

  assign in_ready_o = ld[1];

  // Advance valid bits with their data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ld[1]) begin
        valid_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (ld[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: mask test and side data
  // --------------------------------------------------------------------------
  side_t side_d;
  side_t side_q [1:NumStages-1];

  assign side_d.ok = (depth_mm_i != '0) && (depth_mm_i <= DEPTH_LIMIT_MM) &&
                     ({5'b0, column_i} < MaxCol) && ({5'b0, row_index_i} < MaxRow);
  assign side_d.z  = depth_mm_i[ZW-1:0];
  assign side_d.b  = blue_in_i;
  assign side_d.g  = green_in_i;
  assign side_d.r  = red_in_i;

  // Carry side data down the stages
  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      side_q[1] <= side_d;
    end
    for (int k = 2; k <= NumStages - 1; k++) begin
      if (ld[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1 to 4: projection lanes
  // --------------------------------------------------------------------------
  axis_en_t                 axis_en;
  logic signed [RoundW-1:0] x_rnd, y_rnd;

  assign axis_en.dx    = ld[1];
  assign axis_en.scale = ld[2];
  assign axis_en.focal = ld[3];
  assign axis_en.rnd   = ld[4];

  dpbm_axis u_axis_x (
    .clk_i       (clk_i),
    .en_i        (axis_en),
    .coord_i     (column_i),
    .center_i    (center_x_q),
    .depth_i     (side_q[1].z),
    .inv_focal_i (inv_focal_x_q),
    .coord_q4_o  (x_rnd)
  );

  dpbm_axis u_axis_y (
    .clk_i       (clk_i),
    .en_i        (axis_en),
    .coord_i     (row_index_i),
    .center_i    (center_y_q),
    .depth_i     (side_q[1].z),
    .inv_focal_i (inv_focal_y_q),
    .coord_q4_o  (y_rnd)
  );

  // --------------------------------------------------------------------------
  // Stage 5: saturate and rotate into world z terms
  // --------------------------------------------------------------------------
  logic signed [Q4W-1:0]  xs5_d, ys5_d, xs5_q, ys5_q;
  logic signed [MxyW-1:0] mx5_d, my5_d, mx5_q, my5_q;
  logic signed [MzW-1:0]  mz5_d, mz5_q;

  always_comb begin
    if (x_rnd > RoundW'(Q4_MAX)) begin
      xs5_d = Q4_MAX;
    end else if (x_rnd < RoundW'(Q4_MIN)) begin
      xs5_d = Q4_MIN;
    end else begin
      xs5_d = x_rnd[Q4W-1:0];
    end
    if (y_rnd > RoundW'(Q4_MAX)) begin
      ys5_d = Q4_MAX;
    end else if (y_rnd < RoundW'(Q4_MIN)) begin
      ys5_d = Q4_MIN;
    end else begin
      ys5_d = y_rnd[Q4W-1:0];
    end
  end

  // Floor test uses the unsaturated values
  assign mx5_d = wz_x_q * x_rnd;
  assign my5_d = wz_y_q * y_rnd;
  assign mz5_d = wz_z_q * $signed({1'b0, side_q[4].z, 4'b0000});

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      xs5_q     <= xs5_d;
      ys5_q     <= ys5_d;
      mx5_q     <= mx5_d;
      my5_q     <= my5_d;
      mz5_q     <= mz5_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: world z sum
  // --------------------------------------------------------------------------
  logic signed [Q4W-1:0] xs6_q, ys6_q;
  logic signed [WW-1:0]  w6_d, w6_q;

  assign w6_d = WW'(mx5_q) + WW'(my5_q) + WW'(mz5_q);

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      xs6_q <= xs5_q;
      ys6_q <= ys5_q;
      w6_q  <= w6_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: floor compare, masking, output register
  // --------------------------------------------------------------------------
  logic signed [WW-1:0]  lim;
  logic                  ok6;
  logic                  pv_q, ws_q;
  logic signed [Q4W-1:0] x_q, y_q;
  logic [ZW-1:0]         z_q;
  logic [ColorW-1:0]     b_q, g_q, r_q, a_q;

  assign lim = WW'($signed({z_off_q, 16'h0000}));
  assign ok6 = side_q[6].ok;

  // Zero every field of a masked point
  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      pv_q <= ok6;
      ws_q <= ok6 && (w6_q > lim);
      x_q  <= ok6 ? xs6_q : '0;
      y_q  <= ok6 ? ys6_q : '0;
      z_q  <= ok6 ? side_q[6].z : '0;
      b_q  <= ok6 ? side_q[6].b : '0;
      g_q  <= ok6 ? side_q[6].g : '0;
      r_q  <= ok6 ? side_q[6].r : '0;
      a_q  <= ok6 ? ALPHA_OPAQUE : '0;
    end
  end

  assign out_valid_o    = valid_q[NumStages];
  assign point_valid_o  = pv_q;
  assign x_q4_o         = x_q;
  assign y_q4_o         = y_q;
  assign z_mm_o         = z_q;
  assign blue_out_o     = b_q;
  assign green_out_o    = g_q;
  assign red_out_o      = r_q;
  assign alpha_out_o    = a_q;
  assign in_workspace_o = ws_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DPBM_ASSERT(a_full_when_blocked, !in_ready_o |-> (valid_q == '1))
  `DPBM_ASSERT(a_ws_needs_point, out_valid_o && in_workspace_o |-> point_valid_o)
  `DPBM_ASSERT(a_masked_zero, out_valid_o && !point_valid_o |-> (x_q4_o == '0) && (y_q4_o == '0) && (blue_out_o == '0) && (red_out_o == '0))
  `DPBM_ASSERT(a_alpha_tracks_point, out_valid_o |-> ((alpha_out_o == ALPHA_OPAQUE) == point_valid_o))
  `DPBM_ASSERT(a_depth_tracks_point, out_valid_o |-> ((z_mm_o != '0) == point_valid_o))

endmodule

>>> dv/depth_pixel_backproject_mask_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_backproject_mask_tb
// Drives depth pixels and register writes into the back-projection block.
// It predicts each point with a fixed-point model of its own or takes it from
// the directed table, and checks every output beat against it, field by field.
//
// A short table of directed pixels runs first. It covers invalid depths,
// the principal point, the floor tie and saturated coordinates. Random
// phases follow, each under a new register setting. Both channels idle
// in random patterns.
// ----------------------------------------------------------------------------
module depth_pixel_backproject_mask_tb;
  import dpbm_pkg::*;

  localparam int unsigned FrameCols     = 4096;
  localparam int unsigned FrameRows     = 4096;
  localparam int unsigned NumRegs       = 8;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 230;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned MaxReports    = 10;
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 4'hC;

  typedef logic [CfgDataW-1:0] reg_set_t [NumRegs];

  localparam reg_set_t RegDefaults = '{24'd33554, 24'd33554, 24'd5120, 24'd3840,
                                       24'd0, 24'd0, 24'd65536, 24'd0};
  localparam int unsigned RegWidth [NumRegs] = '{InvW, InvW, CenterW, CenterW,
                                                RotW, RotW, RotW, OffsetW};

  typedef enum int {SETUP_DEFAULT, SETUP_TIE, SETUP_SATURATE} setup_e;
  typedef enum int {SET_DEFAULT, SET_MAX, SET_MIN, SET_RANDOM, SET_TYPICAL,
                    SET_MIXED} setting_e;

  typedef struct packed {
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
    logic [DepthW-1:0] depth;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic                  valid;
    logic signed [Q4W-1:0] x;
    logic signed [Q4W-1:0] y;
    logic [ZW-1:0]         z;
    logic [ColorW-1:0]     blue;
    logic [ColorW-1:0]     green;
    logic [ColorW-1:0]     red;
    logic [ColorW-1:0]     alpha;
    logic                  in_ws;
  } point_t;

  typedef struct {
    setup_e setup;
    pixel_t px;
    bit     typed;
    point_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [CoordW-1:0] column_i;
  logic [CoordW-1:0] row_index_i;
  logic [DepthW-1:0] depth_mm_i;
  logic [ColorW-1:0] blue_in_i;
  logic [ColorW-1:0] green_in_i;
  logic [ColorW-1:0] red_in_i;
  logic out_valid_o;
  logic out_ready_i;
  logic point_valid_o;
  logic signed [Q4W-1:0] x_q4_o;
  logic signed [Q4W-1:0] y_q4_o;
  logic [ZW-1:0] z_mm_o;
  logic [ColorW-1:0] blue_out_o;
  logic [ColorW-1:0] green_out_o;
  logic [ColorW-1:0] red_out_o;
  logic [ColorW-1:0] alpha_out_o;
  logic in_workspace_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Register copy of the predictor
  logic [InvW-1:0]           inv_fx_q24;
  logic [InvW-1:0]           inv_fy_q24;
  logic [CenterW-1:0]        cx_q4;
  logic [CenterW-1:0]        cy_q4;
  logic signed [RotW-1:0]    rot_zx;
  logic signed [RotW-1:0]    rot_zy;
  logic signed [RotW-1:0]    rot_zz;
  logic signed [OffsetW-1:0] floor_off_q4;

  point_t      pending_points[$];
  bit          use_typed;
  point_t      typed_want;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned gap_len;

  depth_pixel_backproject_mask #(
    .MAX_COLUMNS(FrameCols),
    .MAX_ROWS   (FrameRows)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .column_i      (column_i),
    .row_index_i   (row_index_i),
    .depth_mm_i    (depth_mm_i),
    .blue_in_i     (blue_in_i),
    .green_in_i    (green_in_i),
    .red_in_i      (red_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .point_valid_o (point_valid_o),
    .x_q4_o        (x_q4_o),
    .y_q4_o        (y_q4_o),
    .z_mm_o        (z_mm_o),
    .blue_out_o    (blue_out_o),
    .green_out_o   (green_out_o),
    .red_out_o     (red_out_o),
    .alpha_out_o   (alpha_out_o),
    .in_workspace_o(in_workspace_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Divide a Q28 product by 2^24, halves away from zero
  function automatic longint round_q28_to_q4(longint p);
    longint mag;
    mag = (p < 0) ? -p : p;
    mag = (mag + (64'sd1 <<< 23)) >>> 24;
    return (p < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp_q4(longint v);
    if (v > longint'(Q4_MAX)) return longint'(Q4_MAX);
    if (v < longint'(Q4_MIN)) return longint'(Q4_MIN);
    return v;
  endfunction

  // Expected point for one pixel under the current registers
  function automatic point_t project_pixel(pixel_t px);
    point_t pt;
    longint dx, dy, xr, yr, wz, lim;
    pt = '0;
    if (px.depth == 0 || px.depth > DEPTH_LIMIT_MM ||
        px.column >= FrameCols || px.row >= FrameRows) return pt;
    dx = longint'(px.column) * 16 - longint'(cx_q4);
    dy = longint'(px.row) * 16 - longint'(cy_q4);
    xr = round_q28_to_q4(dx * longint'(inv_fx_q24) * longint'(px.depth));
    yr = round_q28_to_q4(dy * longint'(inv_fy_q24) * longint'(px.depth));
    // floor test uses the unsaturated coordinates
    wz = longint'(rot_zx) * xr + longint'(rot_zy) * yr
       + longint'(rot_zz) * (longint'(px.depth) * 16);
    lim = longint'(floor_off_q4) * 65536;
    xr = clamp_q4(xr);
    yr = clamp_q4(yr);
    pt.valid = 1'b1;
    pt.x     = xr[Q4W-1:0];
    pt.y     = yr[Q4W-1:0];
    pt.z     = px.depth[ZW-1:0];
    pt.blue  = px.blue;
    pt.green = px.green;
    pt.red   = px.red;
    pt.alpha = ALPHA_OPAQUE;
    pt.in_ws = (wz > lim);
    return pt;
  endfunction

  // Register values for the directed table
  function automatic reg_set_t setup_regs(setup_e s);
    reg_set_t v;
    v = RegDefaults;
    case (s)
      SETUP_TIE: begin
        // floor right at 16 * 500 mm Q4 with the identity z row
        v[CFG_Z_PLANE_OFFSET] = 24'd8000;
      end
      SETUP_SATURATE: begin
        v[CFG_INV_FOCAL_X]    = 24'hFFFFFF;
        v[CFG_INV_FOCAL_Y]    = 24'hFFFFFF;
        v[CFG_CENTER_X_Q4]    = 24'h008000;
        v[CFG_CENTER_Y_Q4]    = 24'h008000;
        v[CFG_WORLD_Z_FROM_X] = 24'h01FFFF;
        v[CFG_WORLD_Z_FROM_Y] = 24'h020000;
      end
      default: ;
    endcase
    return v;
  endfunction

  // Register values for one random phase; upper data bits are noise
  function automatic reg_set_t random_setting(setting_e kind);
    reg_set_t v;
    logic [CfgDataW-1:0] mask, val;
    setting_e pick;
    for (int i = 0; i < NumRegs; i++) begin
      mask = (RegWidth[i] >= CfgDataW) ? '1 : (24'd1 << RegWidth[i]) - 24'd1;
      pick = (kind == SET_MIXED) ? setting_e'($urandom_range(0, 4)) : kind;
      case (pick)
        SET_DEFAULT: val = RegDefaults[i];
        SET_MAX:     val = (i >= CFG_WORLD_Z_FROM_X) ? (mask >> 1) : mask;
        SET_MIN:     val = (i >= CFG_WORLD_Z_FROM_X) ? ~(mask >> 1) : '0;
        SET_RANDOM:  val = CfgDataW'($urandom());
        default: begin
          case (i)
            CFG_INV_FOCAL_X, CFG_INV_FOCAL_Y:
              val = CfgDataW'($urandom_range(8000, 80000));
            CFG_CENTER_X_Q4, CFG_CENTER_Y_Q4:
              val = CfgDataW'($urandom_range(0, 65520));
            CFG_Z_PLANE_OFFSET:
              val = CfgDataW'($urandom_range(0, 64000) - 32000);
            default:
              val = CfgDataW'($urandom_range(0, 131072) - 65536);
          endcase
        end
      endcase
      v[i] = (CfgDataW'($urandom()) & ~mask) | (val & mask);
    end
    return v;
  endfunction

  // Write all registers, then one unused index that must be ignored
  task automatic write_regs(input reg_set_t vals);
    for (int i = 0; i < NumRegs; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_index_i <= CfgUnusedIdx;
    cfg_data_i  <= CfgDataW'($urandom());
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every expected point is out and the pipeline is empty
  task automatic wait_drained();
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Send one pixel beat; a new burst and gap are chosen when a burst runs out
  task automatic send_pixel(input pixel_t px, input bit last);
    repeat (gap_len) @(posedge clk_i);
    gap_len = 0;
    in_valid_i  <= 1'b1;
    column_i    <= px.column;
    row_index_i <= px.row;
    depth_mm_i  <= px.depth;
    blue_in_i   <= px.blue;
    green_in_i  <= px.green;
    red_in_i    <= px.red;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    if (last || gap_len != 0) in_valid_i <= 1'b0;
  endtask

  // Track register writes and accepted pixels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_fx_q24   = RegDefaults[CFG_INV_FOCAL_X][InvW-1:0];
      inv_fy_q24   = RegDefaults[CFG_INV_FOCAL_Y][InvW-1:0];
      cx_q4        = RegDefaults[CFG_CENTER_X_Q4][CenterW-1:0];
      cy_q4        = RegDefaults[CFG_CENTER_Y_Q4][CenterW-1:0];
      rot_zx       = RegDefaults[CFG_WORLD_Z_FROM_X][RotW-1:0];
      rot_zy       = RegDefaults[CFG_WORLD_Z_FROM_Y][RotW-1:0];
      rot_zz       = RegDefaults[CFG_WORLD_Z_FROM_Z][RotW-1:0];
      floor_off_q4 = RegDefaults[CFG_Z_PLANE_OFFSET][OffsetW-1:0];
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_INV_FOCAL_X:    inv_fx_q24   = cfg_data_i[InvW-1:0];
          CFG_INV_FOCAL_Y:    inv_fy_q24   = cfg_data_i[InvW-1:0];
          CFG_CENTER_X_Q4:    cx_q4        = cfg_data_i[CenterW-1:0];
          CFG_CENTER_Y_Q4:    cy_q4        = cfg_data_i[CenterW-1:0];
          CFG_WORLD_Z_FROM_X: rot_zx       = cfg_data_i[RotW-1:0];
          CFG_WORLD_Z_FROM_Y: rot_zy       = cfg_data_i[RotW-1:0];
          CFG_WORLD_Z_FROM_Z: rot_zz       = cfg_data_i[RotW-1:0];
          CFG_Z_PLANE_OFFSET: floor_off_q4 = cfg_data_i[OffsetW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        pending_points.insert(pending_points.size(), use_typed ? typed_want :
          project_pixel('{column_i, row_index_i, depth_mm_i,
                          blue_in_i, green_in_i, red_in_i}));
      end
    end
  end

  // Compare each output beat with the oldest expected point
  always @(posedge clk_i) begin : check_points
    point_t got, want;
    int nbad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{point_valid_o, x_q4_o, y_q4_o, z_mm_o, blue_out_o, green_out_o,
              red_out_o, alpha_out_o, in_workspace_o};
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("ERROR: point beat with nothing expected: %p", got);
      end else begin
        want = pending_points.pop_front();
        nbad = int'(got.valid !== want.valid) + int'(got.x !== want.x)
             + int'(got.y !== want.y) + int'(got.z !== want.z)
             + int'(got.blue !== want.blue) + int'(got.green !== want.green)
             + int'(got.red !== want.red) + int'(got.alpha !== want.alpha)
             + int'(got.in_ws !== want.in_ws);
        if (nbad != 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("ERROR: point mismatch in %0d field(s)", nbad);
            $display("  expected valid %0b x %0d y %0d z %0d bgra %0d %0d %0d %0d ws %0b",
                     want.valid, want.x, want.y, want.z, want.blue, want.green,
                     want.red, want.alpha, want.in_ws);
            $display("  actual   valid %0b x %0d y %0d z %0d bgra %0d %0d %0d %0d ws %0b",
                     got.valid, got.x, got.y, got.z, got.blue, got.green,
                     got.red, got.alpha, got.in_ws);
          end
        end
      end
    end
  end

  // Receiver stall pattern: stretches of full rate, light, heavy and
  // periodic back-pressure
  always begin : ready_pattern
    int unsigned span, style, k;
    style = $urandom_range(0, 3);
    span  = $urandom_range(8, 60);
    for (k = 0; k < span; k++) begin
      @(posedge clk_i);
      case (style)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 3) != 0);
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (k % 9 == 8);
      endcase
    end
  end

  // Cycle limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("depth_pixel_backproject_mask test failed");
    $finish;
  end

  initial begin : stimulus
    dir_row_t dir_rows[$];
    setup_e   cur_setup;
    pixel_t   px;
    point_t   center_pt;
    int unsigned dsel;
    bit       last;

    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    column_i    = '0;
    row_index_i = '0;
    depth_mm_i  = '0;
    blue_in_i   = '0;
    green_in_i  = '0;
    red_in_i    = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_INV_FOCAL_X;
    cfg_data_i  = '0;
    use_typed   = 1'b0;
    typed_want  = '0;
    mismatches  = 0;
    burst_left  = 0;
    gap_len     = 0;

    // Principal point under defaults: x and y are zero, z row is identity
    center_pt = '{1'b1, 19'sd0, 19'sd0, 10'd1000, 8'd12, 8'd34, 8'd56,
                  ALPHA_OPAQUE, 1'b1};

    // Invalid depths, extremes and the principal point under defaults
    dir_rows.insert(dir_rows.size(),
      '{SETUP_DEFAULT, '{12'd0, 12'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '0});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_DEFAULT, '{12'd4095, 12'd4095, 16'd1001, 8'hA5, 8'h5A, 8'hFF}, 1'b1, '0});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_DEFAULT, '{12'd2048, 12'd17, 16'd65535, 8'h01, 8'h80, 8'h7F}, 1'b1, '0});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_DEFAULT, '{12'd320, 12'd240, 16'd1000, 8'd12, 8'd34, 8'd56}, 1'b1,
        center_pt});
    center_pt.z = 10'd1;
    center_pt.blue = 8'd255; center_pt.green = 8'd0; center_pt.red = 8'd255;
    dir_rows.insert(dir_rows.size(),
      '{SETUP_DEFAULT, '{12'd320, 12'd240, 16'd1, 8'd255, 8'd0, 8'd255}, 1'b1,
        center_pt});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_DEFAULT, '{12'd0, 12'd0, 16'd1000, 8'd1, 8'd2, 8'd3}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_DEFAULT, '{12'd4095, 12'd4095, 16'd1000, 8'd4, 8'd5, 8'd6}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_DEFAULT, '{12'd0, 12'd4095, 16'd777, 8'd7, 8'd8, 8'd9}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_DEFAULT, '{12'd4095, 12'd0, 16'd1, 8'd10, 8'd11, 8'd12}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_DEFAULT, '{12'd321, 12'd239, 16'd3, 8'd13, 8'd14, 8'd15}, 1'b0, '0});
    // Floor tie: world z equal to the offset is not above the floor
    center_pt.blue = 8'd20; center_pt.green = 8'd30; center_pt.red = 8'd40;
    center_pt.z = 10'd500; center_pt.in_ws = 1'b0;
    dir_rows.insert(dir_rows.size(),
      '{SETUP_TIE, '{12'd320, 12'd240, 16'd500, 8'd20, 8'd30, 8'd40}, 1'b1, center_pt});
    center_pt.z = 10'd501; center_pt.in_ws = 1'b1;
    dir_rows.insert(dir_rows.size(),
      '{SETUP_TIE, '{12'd320, 12'd240, 16'd501, 8'd20, 8'd30, 8'd40}, 1'b1, center_pt});
    center_pt.z = 10'd499; center_pt.in_ws = 1'b0;
    dir_rows.insert(dir_rows.size(),
      '{SETUP_TIE, '{12'd320, 12'd240, 16'd499, 8'd20, 8'd30, 8'd40}, 1'b1, center_pt});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_TIE, '{12'd0, 12'd0, 16'd500, 8'd21, 8'd31, 8'd41}, 1'b0, '0});
    // Coordinate overflow in both directions
    dir_rows.insert(dir_rows.size(),
      '{SETUP_SATURATE, '{12'd0, 12'd0, 16'd1000, 8'd50, 8'd60, 8'd70}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_SATURATE, '{12'd4095, 12'd4095, 16'd1000, 8'd51, 8'd61, 8'd71}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_SATURATE, '{12'd0, 12'd4095, 16'd1000, 8'd52, 8'd62, 8'd72}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_SATURATE, '{12'd2048, 12'd2048, 16'd1000, 8'd53, 8'd63, 8'd73}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_SATURATE, '{12'd2049, 12'd2047, 16'd1, 8'd54, 8'd64, 8'd74}, 1'b0, '0});
    dir_rows.insert(dir_rows.size(),
      '{SETUP_SATURATE, '{12'd4095, 12'd0, 16'd0, 8'd55, 8'd65, 8'd75}, 1'b1, '0});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; registers change only with the pipeline empty
    cur_setup = SETUP_DEFAULT;
    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].setup != cur_setup) begin
        wait_drained();
        cur_setup = dir_rows[i].setup;
        write_regs(setup_regs(cur_setup));
      end
      last = (i == dir_rows.size() - 1) || (dir_rows[i + 1].setup != cur_setup);
      // Update with the beat so the tracker still sees the previous row's values
      use_typed  <= dir_rows[i].typed;
      typed_want <= dir_rows[i].want;
      send_pixel(dir_rows[i].px, last);
    end
    use_typed <= 1'b0;

    // Random phases: defaults, all maxima, all minima, typical values, then mixed settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      write_regs(random_setting((ph < 4) ? setting_e'(ph == 3 ? SET_TYPICAL : ph)
                                         : SET_MIXED));
      for (int n = 0; n < ItemsPerPhase; n++) begin
        dsel = $urandom_range(0, 19);
        if (dsel < 2)       px.depth = '0;
        else if (dsel < 5)  px.depth = DepthW'($urandom_range(1001, 65535));
        else if (dsel == 5) px.depth = DEPTH_LIMIT_MM;
        else if (dsel == 6) px.depth = 16'd1;
        else                px.depth = DepthW'($urandom_range(1, 1000));
        case ($urandom_range(0, 7))
          0:       px.column = '0;
          1:       px.column = '1;
          default: px.column = CoordW'($urandom());
        endcase
        case ($urandom_range(0, 7))
          0:       px.row = '0;
          1:       px.row = '1;
          default: px.row = CoordW'($urandom());
        endcase
        px.blue  = ColorW'($urandom());
        px.green = ColorW'($urandom());
        px.red   = ColorW'($urandom());
        send_pixel(px, n == ItemsPerPhase - 1);
      end
    end

    wait_drained();
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("depth_pixel_backproject_mask test passed");
    end else begin
      $display("depth_pixel_backproject_mask test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/dpbm_pkg.sv
src/dpbm_axis.sv
src/depth_pixel_backproject_mask.sv
dv/depth_pixel_backproject_mask_tb.sv
